// File: rtl/bhff_pkg.sv
`default_nettype none
package bhff_pkg;

  // "BEGINHDR" with the first character in the low byte
  localparam logic [63:0] MARK_BEGIN  = 64'h5244484E49474542;
  // "ENDH"
  localparam logic [31:0] MARK_END    = 32'h48444E45;
  // "LOAD"
  localparam logic [31:0] LABEL_RESET = 32'h44414F4C;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } step_t;

  typedef struct packed {
    logic [31:0] field_value;
    logic        found;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/bhff_in_if.sv
`default_nettype none
interface bhff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/bhff_out_if.sv
`default_nettype none
interface bhff_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_value;
  logic        found;

  modport source (output valid, output field_value, output found, input ready);
  modport sink (input valid, input field_value, input found, output ready);
endinterface
`default_nettype wire

// File: rtl/bhff_scan.sv
`default_nettype none
module bhff_scan #(
  parameter int BEGIN_LIMIT  = 128,
  parameter int HEADER_LIMIT = 256
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    step_en,
  input  bhff_pkg::step_t        step,
  input  wire                    cfg_we,
  input  wire  [31:0]            cfg_data,
  output bhff_pkg::result_t      res
);
  import bhff_pkg::*;

  localparam int OFFSET_SAT = (BEGIN_LIMIT + HEADER_LIMIT > 511) ?
                              (BEGIN_LIMIT + HEADER_LIMIT) : 511;
  localparam int OFF_W = $clog2(OFFSET_SAT + 1);
  localparam int END_W = OFF_W + 1;
  localparam int HS_W  = $clog2(BEGIN_LIMIT + 1);

  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [31:0]      label_code;
  logic [OFF_W-1:0] byte_offset;
  logic [63:0]      window_bytes;
  logic [1:0]       scan_phase;
  logic [HS_W-1:0]  header_start;
  logic [31:0]      held_value;
  logic             held_found;

  logic [63:0]      window_next;
  logic [1:0]       phase_next;
  logic [HS_W-1:0]  start_next;
  logic [31:0]      value_next;
  logic             found_next;
  logic [END_W-1:0] end_cnt;
  logic [END_W-1:0] rel;

  assign window_next = {step.data_byte, window_bytes[63:8]};
  assign end_cnt     = {1'b0, byte_offset} + END_W'(1);
  assign rel         = end_cnt - {{(END_W-HS_W){1'b0}}, header_start};

  always_comb begin
    phase_next = scan_phase;
    start_next = header_start;
    value_next = held_value;
    found_next = held_found;
    case (scan_phase)
      PH_SEEK: begin
        // marker ending here starts at a multiple of four from offset 8
        if (end_cnt >= END_W'(16) && end_cnt[1:0] == 2'b00 &&
            end_cnt <= END_W'(BEGIN_LIMIT) && window_next == MARK_BEGIN) begin
          start_next = end_cnt[HS_W-1:0];
          phase_next = PH_HDR;
        end
      end
      PH_HDR: begin
        if (end_cnt >= {{(END_W-HS_W){1'b0}}, header_start}) begin
          if (rel > END_W'(HEADER_LIMIT)) begin
            phase_next = PH_DONE;
          end else if (rel >= END_W'(8) && rel[2:0] == 3'b000) begin
            if (window_next[31:0] == MARK_END) begin
              phase_next = PH_DONE;
            end else if (window_next[31:0] == label_code) begin
              value_next = window_next[63:32];
              found_next = 1'b1;
              phase_next = PH_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res.field_value = value_next;
  assign res.found       = found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_code <= LABEL_RESET;
    end else if (cfg_we) begin
      label_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      window_bytes <= '0;
      scan_phase   <= PH_SEEK;
      header_start <= '0;
      held_value   <= '0;
      held_found   <= 1'b0;
    end else if (step_en) begin
      if (step.is_last) begin
        byte_offset  <= '0;
        window_bytes <= '0;
        scan_phase   <= PH_SEEK;
        header_start <= '0;
        held_value   <= '0;
        held_found   <= 1'b0;
      end else begin
        if (byte_offset < OFF_W'(OFFSET_SAT)) begin
          byte_offset <= byte_offset + OFF_W'(1);
        end
        window_bytes <= window_next;
        scan_phase   <= phase_next;
        header_start <= start_next;
        held_value   <= value_next;
        held_found   <= found_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/boot_header_field_finder_unit.sv
`default_nettype none
// An accepted last byte is held in the input register; its result is then held in the result register.
// Throughput: one byte per cycle; a byte leaves the input register every cycle
// unless it is a last byte and the result register is full and not taken.
// Reset (rst, synchronous): clears scan state, empties both registers and
// loads the label register with "LOAD".
module boot_header_field_finder_unit #(
  parameter int BEGIN_LIMIT  = 128,
  parameter int HEADER_LIMIT = 256
) (
  input  wire         clk,
  input  wire         rst,
  bhff_in_if.sink     in_ch,
  bhff_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_data
);
  import bhff_pkg::*;

  logic    s1_valid;
  step_t   s1_step;
  logic    out_valid;
  result_t out_res;
  result_t scan_res;
  logic    advance;
  logic    step_en;

  // only a last byte needs room in the result register
  assign advance     = !out_valid || out_ch.ready;
  assign step_en     = s1_valid && (advance || !s1_step.is_last);
  assign in_ch.ready = !s1_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_step.data_byte <= in_ch.data_byte;
      s1_step.is_last   <= in_ch.is_last;
    end
  end

  bhff_scan #(
    .BEGIN_LIMIT  (BEGIN_LIMIT),
    .HEADER_LIMIT (HEADER_LIMIT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step_en),
    .step     (s1_step),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .res      (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_en && s1_step.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && s1_step.is_last) begin
      out_res <= scan_res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.field_value = out_res.field_value;
  assign out_ch.found       = out_res.found;

  // a stalled byte in the input register is never dropped or overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !step_en |=> s1_valid && $stable(s1_step))
    else $error("input register changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

  a_zero_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.found |-> out_res.field_value == 32'd0)
    else $error("nonzero value without a match");

endmodule
`default_nettype wire
